// ----- src/tccw_pkg.sv -----
// shared types and constants of the text console cell writer
`default_nettype none

package tccw_pkg;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] DFLT_ATTR_RST = 8'd15;

    typedef enum logic [2:0] {
        KIND_PUT    = 3'd0,
        KIND_PUT_AT = 3'd1,
        KIND_MOVE   = 3'd2,
        KIND_CLEAR  = 3'd3,
        KIND_READ   = 3'd4
    } tccw_kind_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADDR,
        OP_PUT,
        OP_MOVE,
        OP_RD_ISSUE,
        OP_RD_CAPTURE,
        OP_CLR_ISSUE,
        OP_CLR_CAPTURE,
        OP_FILL,
        OP_SCROLL
    } tccw_op_t;

    typedef struct packed {
        tccw_op_t op;
        logic     fill_blank;
        logic     out_load;
    } tccw_cmd_t;

    typedef struct packed {
        logic [2:0] in_kind;
        logic [2:0] kind;
        logic       scroll_need;
        logic       fill_last;
        logic       scroll_last;
        logic       out_free;
    } tccw_sts_t;

endpackage

`default_nettype wire

// ----- src/tccw_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire                     re,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/tccw_dpath.sv -----
// datapath: cell store, cursor, sweep counter and result register
`default_nettype none

module tccw_dpath import tccw_pkg::*; #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire  [31:0] s_axis_tdata,
    input  wire  [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,
    input  wire         cfg_we,
    input  wire  [7:0]  cfg_wdata,
    input  tccw_cmd_t   cmd,
    output tccw_sts_t   sts
);

    localparam int CELLS      = COLS * ROWS;
    localparam int AW         = $clog2(CELLS);
    localparam int SW         = $clog2(CELLS + 1);
    localparam int CW         = $clog2(COLS);
    localparam int RW         = $clog2(ROWS);
    localparam int ROW2_START = (ROWS - 2) * COLS;
    localparam int BOT_START  = (ROWS - 1) * COLS;

    logic [7:0]    in_char;
    logic [6:0]    in_column;
    logic [4:0]    in_row;
    logic [7:0]    in_attr;
    logic [CW-1:0] tgt_col;
    logic [RW-1:0] tgt_row;

    logic [7:0]    dflt_attr_reg;
    tccw_kind_t    kind_reg;
    logic [7:0]    char_reg;
    logic [7:0]    attr_reg;
    logic [CW-1:0] tgt_col_reg;
    logic [RW-1:0] tgt_row_reg;
    logic [CW-1:0] pos_col_reg;
    logic [RW-1:0] pos_row_reg;
    logic [AW-1:0] addr_reg;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic          scrolled_reg;
    logic [7:0]    rd_char_reg;
    logic [7:0]    rd_attr_reg;
    logic [15:0]   old_last_reg;
    logic [SW-1:0] sweep_reg;
    logic          out_valid_reg;
    logic [31:0]   out_data_reg;

    logic          is_nl, is_bs, at_last_row, col_near_end, at_origin, scroll_need;
    logic [CW-1:0] sel_col;
    logic [RW-1:0] sel_row;
    logic [15:0]   fill_word;
    logic [SW:0]   scroll_src;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;
    logic [31:0]   col32, row32;

    assign in_char   = s_axis_tdata[7:0];
    assign in_column = s_axis_tdata[14:8];
    assign in_row    = s_axis_tdata[19:15];
    assign in_attr   = s_axis_tdata[27:20];

    // out of range coordinates saturate to the last column or row
    always_comb
    begin
        if (int'(in_column) > COLS - 1)
            tgt_col = CW'(COLS - 1);
        else
            tgt_col = CW'(in_column);
        if (int'(in_row) > ROWS - 1)
            tgt_row = RW'(ROWS - 1);
        else
            tgt_row = RW'(in_row);
    end

    assign sel_col = (kind_reg == KIND_PUT) ? cur_col_reg : tgt_col_reg;
    assign sel_row = (kind_reg == KIND_PUT) ? cur_row_reg : tgt_row_reg;

    assign is_nl        = (char_reg == CH_NEWLINE);
    assign is_bs        = (char_reg == CH_BACKSPACE);
    assign at_last_row  = (pos_row_reg == RW'(ROWS - 1));
    assign col_near_end = (int'(pos_col_reg) >= COLS - 2);
    assign at_origin    = (addr_reg == '0);
    assign scroll_need  = !is_bs && at_last_row && (is_nl || col_near_end);

    // cursor after a character write
    always_comb
    begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (is_nl)
        begin
            cur_col_next = '0;
            cur_row_next = at_last_row ? pos_row_reg : pos_row_reg + RW'(1);
        end
        else if (is_bs)
        begin
            if (!at_origin)
            begin
                if (pos_col_reg == '0)
                begin
                    cur_col_next = CW'(COLS - 1);
                    cur_row_next = pos_row_reg - RW'(1);
                end
                else
                begin
                    cur_col_next = pos_col_reg - CW'(1);
                    cur_row_next = pos_row_reg;
                end
            end
        end
        else if (scroll_need)
        begin
            cur_col_next = '0;
            cur_row_next = RW'(ROWS - 1);
        end
        else if (pos_col_reg == CW'(COLS - 1))
        begin
            cur_col_next = '0;
            cur_row_next = pos_row_reg + RW'(1);
        end
        else
        begin
            cur_col_next = pos_col_reg + CW'(1);
            cur_row_next = pos_row_reg;
        end
    end

    // screen image left by a clear, including its two closing scrolls; all zeros when fill_blank is set
    always_comb
    begin
        priority if (cmd.fill_blank)
            fill_word = '0;
        else if (int'(sweep_reg) == ROW2_START - 1)
            fill_word = old_last_reg;
        else if (int'(sweep_reg) == BOT_START - 1)
            fill_word = {dflt_attr_reg, CH_SPACE};
        else if (int'(sweep_reg) < ROW2_START)
            fill_word = {dflt_attr_reg, CH_SPACE};
        else
            fill_word = '0;
    end

    assign scroll_src = {1'b0, sweep_reg} + (SW + 1)'(COLS);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = {attr_reg, char_reg};
        ram_re    = 1'b0;
        ram_raddr = addr_reg;
        unique case (cmd.op)
            OP_PUT:
            begin
                ram_we = !is_nl && !(is_bs && at_origin);
                if (is_bs)
                begin
                    ram_waddr = addr_reg - AW'(1);
                    ram_wdata = {attr_reg, CH_SPACE};
                end
            end
            OP_RD_ISSUE:
            begin
                ram_re = 1'b1;
            end
            OP_CLR_ISSUE:
            begin
                ram_re    = 1'b1;
                ram_raddr = AW'(CELLS - 1);
            end
            OP_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(sweep_reg);
                ram_wdata = fill_word;
            end
            OP_SCROLL:
            begin
                ram_re    = (int'(sweep_reg) < CELLS - COLS);
                ram_raddr = scroll_src[AW-1:0];
                ram_we    = (sweep_reg != '0);
                ram_waddr = AW'(sweep_reg - SW'(1));
                ram_wdata = (int'(sweep_reg) <= CELLS - COLS) ? ram_rdata : '0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    tccw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_attr_reg <= DFLT_ATTR_RST;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            scrolled_reg  <= 1'b0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dflt_attr_reg <= cfg_wdata;
            end
            if (cmd.op == OP_FILL || cmd.op == OP_SCROLL)
                sweep_reg <= sweep_reg + SW'(1);
            else
                sweep_reg <= '0;
            unique case (cmd.op)
                OP_LOAD:
                begin
                    scrolled_reg <= 1'b0;
                end
                OP_PUT:
                begin
                    cur_col_reg <= cur_col_next;
                    cur_row_reg <= cur_row_next;
                    if (scroll_need)
                        scrolled_reg <= 1'b1;
                end
                OP_MOVE:
                begin
                    cur_col_reg <= tgt_col_reg;
                    cur_row_reg <= tgt_row_reg;
                end
                OP_CLR_CAPTURE:
                begin
                    cur_col_reg  <= '0;
                    cur_row_reg  <= '0;
                    scrolled_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign col32 = 32'(cur_col_reg);
    assign row32 = 32'(cur_row_reg);

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                kind_reg    <= tccw_kind_t'(s_axis_tuser);
                char_reg    <= in_char;
                attr_reg    <= (in_attr == 8'd0) ? dflt_attr_reg : in_attr;
                tgt_col_reg <= tgt_col;
                tgt_row_reg <= tgt_row;
                rd_char_reg <= '0;
                rd_attr_reg <= '0;
            end
            OP_ADDR:
            begin
                pos_col_reg <= sel_col;
                pos_row_reg <= sel_row;
                addr_reg    <= AW'(sel_row) * AW'(COLS) + AW'(sel_col);
            end
            OP_RD_CAPTURE:
            begin
                rd_char_reg <= ram_rdata[7:0];
                rd_attr_reg <= ram_rdata[15:8];
            end
            OP_CLR_CAPTURE:
            begin
                old_last_reg <= ram_rdata;
            end
            default:
            begin
            end
        endcase
        if (cmd.out_load)
        begin
            out_data_reg <= {3'b000, rd_attr_reg, rd_char_reg, scrolled_reg,
                             row32[4:0], col32[6:0]};
        end
    end

    assign sts.in_kind     = s_axis_tuser;
    assign sts.kind        = kind_reg;
    assign sts.scroll_need = scroll_need;
    assign sts.fill_last   = (int'(sweep_reg) == CELLS - 1);
    assign sts.scroll_last = (int'(sweep_reg) == CELLS);
    assign sts.out_free    = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- src/tccw_ctrl.sv -----
// controller state machine sequencing each request through the datapath
`default_nettype none

module tccw_ctrl import tccw_pkg::*; (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  tccw_sts_t  sts,
    output tccw_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ADDR,
        S_PUT,
        S_MOVE,
        S_READ,
        S_RDCAP,
        S_SCROLL,
        S_CLR_RD,
        S_CLR_CAP,
        S_FILL,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        cmd.fill_blank = 1'b0;
        cmd.out_load   = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.op         = OP_FILL;
                cmd.fill_blank = 1'b1;
                if (sts.fill_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.op = OP_LOAD;
                    unique case (sts.in_kind)
                        KIND_PUT, KIND_PUT_AT, KIND_READ: state_next = S_ADDR;
                        KIND_MOVE:                        state_next = S_MOVE;
                        KIND_CLEAR:                       state_next = S_CLR_RD;
                        default:                          state_next = S_DONE;
                    endcase
                end
            end
            S_ADDR:
            begin
                cmd.op     = OP_ADDR;
                state_next = (sts.kind == KIND_READ) ? S_READ : S_PUT;
            end
            S_PUT:
            begin
                cmd.op     = OP_PUT;
                state_next = sts.scroll_need ? S_SCROLL : S_DONE;
            end
            S_MOVE:
            begin
                cmd.op     = OP_MOVE;
                state_next = S_DONE;
            end
            S_READ:
            begin
                cmd.op     = OP_RD_ISSUE;
                state_next = S_RDCAP;
            end
            S_RDCAP:
            begin
                cmd.op     = OP_RD_CAPTURE;
                state_next = S_DONE;
            end
            S_SCROLL:
            begin
                cmd.op = OP_SCROLL;
                if (sts.scroll_last)
                    state_next = S_DONE;
            end
            S_CLR_RD:
            begin
                cmd.op     = OP_CLR_ISSUE;
                state_next = S_CLR_CAP;
            end
            S_CLR_CAP:
            begin
                cmd.op     = OP_CLR_CAPTURE;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                cmd.op = OP_FILL;
                if (sts.fill_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    a_put_no_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT && !sts.scroll_need) |=> (state_reg == S_DONE))
        else $error("character write without scroll did not finish");

    a_scroll_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCROLL && sts.scroll_last) |=> (state_reg == S_DONE))
        else $error("scroll sweep overran its end");

    a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_INIT) |=> (state_reg != S_INIT))
        else $error("store clearing pass restarted");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !sts.out_free) |=> (state_reg == S_DONE))
        else $error("result dropped while output register busy");

endmodule

`default_nettype wire

// ----- src/text_console_cell_writer.sv -----
// top level of the text console cell writer
//
// usage:
//   s_axis carries one request: tuser selects the kind (write at cursor,
//   write at cell, move cursor, clear, read cell), tdata the character,
//   target column and row, and attribute. an attribute of zero takes the
//   default attribute from the cfg_we / cfg_wdata register
//   m_axis returns one result per request: cursor position after it,
//   a scroll flag and, for reads, the cell contents
//   sequence: a move loads the request and sets the cursor; a write loads it,
//   forms the cell address and then writes through the single write port of
//   the cell ram; a read forms the address, reads the single registered read
//   port and captures the cell. a write that scrolls adds a row copy over the
//   whole store; a clear reads and keeps the last cell, then refills the store
//   reset: the cell ram is zeroed by a pass over every cell during which
//   no request is taken; the cursor goes to cell 0 and the default
//   attribute to 15
//   a stalled m_axis holds its result; the block then finishes the next
//   request up to its result and waits with s_axis_tready low
`default_nettype none

module text_console_cell_writer import tccw_pkg::*; #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // char_code[7:0], column[14:8], row[19:15], attribute[27:20]
    input  wire  [31:0] s_axis_tdata,
    // kind[2:0]
    input  wire  [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // cursor_column[6:0], cursor_row[11:7], scrolled[12],
    // read_char[20:13], read_attribute[28:21]
    output logic [31:0] m_axis_tdata,
    input  wire         cfg_we,
    input  wire  [7:0]  cfg_wdata
);

    tccw_cmd_t cmd;
    tccw_sts_t sts;

    tccw_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    tccw_dpath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

`default_nettype wire

// ----- tb/tb_text_console_cell_writer.sv -----
// self-checking testbench for the text console cell writer
`default_nettype none

module tb_text_console_cell_writer import tccw_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = COLS * ROWS;
    localparam int LIMIT_CYCLES = 10_000_000;
    localparam int RANDOM_PER_PHASE = 275;
    localparam int MAX_REPORTS = 40;

    // kinds outside the package enum, accepted and ignored by the block
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] ch;
        logic [6:0] col;
        logic [4:0] row;
        logic [7:0] attr;
    } console_request_t;

    typedef struct {
        logic [6:0] col;
        logic [4:0] row;
        logic       scrolled;
        logic [7:0] rd_char;
        logic [7:0] rd_attr;
    } console_status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [31:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = '0;

    console_request_t requests_pending[$];
    console_status_t  status_due[$];
    console_request_t on_bus;

    // predictor state
    logic [15:0] screen [0:CELLS-1];
    int unsigned cursor_pos;
    logic [7:0]  dflt_attr;
    bit          scroll_flag;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int checked_count = 0;
    int read_count = 0;
    int clear_count = 0;
    int scroll_count = 0;
    int cycle_count = 0;

    text_console_cell_writer #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int unsigned settle_scroll(int unsigned p);
        if (p >= CELLS - 1)
        begin
            for (int i = 0; i < CELLS - COLS; i++)
                screen[i] = screen[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++)
                screen[i] = '0;
            scroll_flag = 1'b1;
            p = CELLS - COLS;
        end
        return p;
    endfunction

    function automatic void place_char(logic [7:0] ch, int unsigned p, logic [7:0] attr);
        if (attr == 8'd0)
            attr = dflt_attr;
        if (ch == CH_NEWLINE)
        begin
            p = (p / COLS) * COLS + COLS - 1;
        end
        else if (ch == CH_BACKSPACE)
        begin
            // nothing happens at the first cell
            if (p > 0)
            begin
                screen[p - 1] = {attr, CH_SPACE};
                cursor_pos = p - 1;
            end
            return;
        end
        else
        begin
            screen[p] = {attr, ch};
        end
        cursor_pos = settle_scroll(p + 1);
    endfunction

    function automatic console_status_t advance_console(console_request_t r);
        console_status_t st;
        int unsigned     c;
        int unsigned     rw;
        int unsigned     target;
        c = (int'(r.col) > COLS - 1) ? COLS - 1 : int'(r.col);
        rw = (int'(r.row) > ROWS - 1) ? ROWS - 1 : int'(r.row);
        target = rw * COLS + c;
        scroll_flag = 1'b0;
        st.rd_char = '0;
        st.rd_attr = '0;
        case (r.kind)
            KIND_PUT:    place_char(r.ch, cursor_pos, r.attr);
            KIND_PUT_AT: place_char(r.ch, target, r.attr);
            KIND_MOVE:   cursor_pos = target;
            KIND_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    place_char(CH_SPACE, i, dflt_attr);
                cursor_pos = 0;
                clear_count++;
            end
            KIND_READ:
            begin
                st.rd_char = screen[target][7:0];
                st.rd_attr = screen[target][15:8];
                read_count++;
            end
            default: ;
        endcase
        if (scroll_flag)
            scroll_count++;
        st.col = 7'(cursor_pos % COLS);
        st.row = 5'(cursor_pos / COLS);
        st.scrolled = scroll_flag;
        return st;
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                status_due.push_back(advance_console(on_bus));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (requests_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_bus = requests_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {4'b0, on_bus.attr, on_bus.row, on_bus.col, on_bus.ch};
                    s_axis_tuser <= on_bus.kind;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t mismatch, %s: got %0d want %0d", $realtime, what, got, want);
    endtask

    // result monitor
    always @(posedge clk)
    begin : check_result
        console_status_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (status_due.size() == 0)
            begin
                report_mismatch("result with no request pending", int'(m_axis_tdata), 0);
            end
            else
            begin
                want = status_due.pop_front();
                checked_count++;
                if (m_axis_tdata[6:0] !== want.col)
                    report_mismatch("cursor_column", int'(m_axis_tdata[6:0]),
                                    int'(want.col));
                if (m_axis_tdata[11:7] !== want.row)
                    report_mismatch("cursor_row", int'(m_axis_tdata[11:7]), int'(want.row));
                if (m_axis_tdata[12] !== want.scrolled)
                    report_mismatch("scrolled", int'(m_axis_tdata[12]), int'(want.scrolled));
                if (m_axis_tdata[20:13] !== want.rd_char)
                    report_mismatch("read_char", int'(m_axis_tdata[20:13]),
                                    int'(want.rd_char));
                if (m_axis_tdata[28:21] !== want.rd_attr)
                    report_mismatch("read_attribute", int'(m_axis_tdata[28:21]),
                                    int'(want.rd_attr));
            end
        end
    end

    function automatic void queue_request(logic [2:0] kind, logic [7:0] ch, logic [6:0] col,
                                          logic [4:0] row, logic [7:0] attr);
        console_request_t r;
        r.kind = kind;
        r.ch = ch;
        r.col = col;
        r.row = row;
        r.attr = attr;
        requests_pending.push_back(r);
    endfunction

    function automatic logic [6:0] pick_col();
        return ($urandom_range(99) < 85) ? 7'($urandom_range(COLS - 1))
                                         : 7'($urandom_range(127, COLS));
    endfunction

    function automatic logic [4:0] pick_row();
        int p;
        p = $urandom_range(99);
        if (p < 10)
            return 5'(ROWS - 1);
        return (p < 88) ? 5'($urandom_range(ROWS - 1)) : 5'($urandom_range(31, ROWS));
    endfunction

    function automatic logic [7:0] pick_char();
        int p;
        p = $urandom_range(99);
        if (p < 10)
            return CH_NEWLINE;
        if (p < 18)
            return CH_BACKSPACE;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_attr();
        return ($urandom_range(99) < 30) ? 8'd0 : 8'($urandom_range(255));
    endfunction

    function automatic int queue_random_burst();
        int         pick;
        int         len;
        int         n;
        logic [6:0] c;
        logic [4:0] r;
        pick = $urandom_range(99);
        n = 0;
        if (pick < 50)
        begin
            // a line of text, often from a fresh cursor position
            if ($urandom_range(1))
            begin
                queue_request(KIND_MOVE, 8'($urandom_range(255)), pick_col(), pick_row(),
                              8'($urandom_range(255)));
                n++;
            end
            len = $urandom_range(20, 3);
            repeat (len)
                queue_request(KIND_PUT, pick_char(), 7'($urandom_range(127)),
                              5'($urandom_range(31)), pick_attr());
            n += len;
        end
        else if (pick < 70)
        begin
            // write a cell and read it back
            c = pick_col();
            r = pick_row();
            queue_request(KIND_PUT_AT, pick_char(), c, r, pick_attr());
            queue_request(KIND_READ, 8'($urandom_range(255)), c, r, 8'($urandom_range(255)));
            n = 2;
        end
        else if (pick < 90)
        begin
            queue_request(KIND_READ, 8'($urandom_range(255)), pick_col(), pick_row(),
                          8'($urandom_range(255)));
            n = 1;
        end
        else if (pick < 98)
        begin
            queue_request(3'($urandom_range(7)), 8'($urandom_range(255)),
                          7'($urandom_range(127)), 5'($urandom_range(31)),
                          8'($urandom_range(255)));
            n = 1;
        end
        else
        begin
            queue_request(KIND_CLEAR, 8'($urandom_range(255)), 7'($urandom_range(127)),
                          5'($urandom_range(31)), 8'($urandom_range(255)));
            n = 1;
        end
        return n;
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (requests_pending.size() != 0 || s_axis_tvalid || status_due.size() != 0);
    endtask

    task automatic set_default_attr(logic [7:0] value);
        wait_idle();
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        dflt_attr = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles", cycle_count);
        $display("[text_console_cell_writer] ERROR");
        $finish;
    end

    initial
    begin
        int queued;
        for (int i = 0; i < CELLS; i++)
            screen[i] = '0;
        cursor_pos = 0;
        dflt_attr = DFLT_ATTR_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, special characters, saturation, scroll threshold, clear
        queue_request(KIND_READ, 8'd0, 7'd0, 5'd0, 8'd0);
        queue_request(KIND_PUT, "A", 7'd0, 5'd0, 8'd0);
        queue_request(KIND_PUT, 8'h00, 7'd127, 5'd31, 8'hFF);
        queue_request(KIND_PUT, 8'hFF, 7'd0, 5'd0, 8'h01);
        queue_request(KIND_PUT, CH_NEWLINE, 7'd0, 5'd0, 8'd0);
        queue_request(KIND_PUT, CH_BACKSPACE, 7'd0, 5'd0, 8'h80);
        queue_request(KIND_MOVE, 8'd0, 7'd0, 5'd0, 8'd0);
        queue_request(KIND_PUT, CH_BACKSPACE, 7'd0, 5'd0, 8'h55);
        queue_request(KIND_PUT_AT, "L", 7'(COLS - 1), 5'(ROWS - 1), 8'h2A);
        queue_request(KIND_PUT_AT, "K", 7'(COLS - 2), 5'(ROWS - 1), 8'd0);
        queue_request(KIND_PUT_AT, "Z", 7'd127, 5'd31, 8'hC3);
        queue_request(KIND_MOVE, 8'd0, 7'd127, 5'd31, 8'd0);
        queue_request(KIND_PUT, "q", 7'd0, 5'd0, 8'd0);
        queue_request(KIND_MOVE, 8'd0, 7'd0, 5'(ROWS - 1), 8'd0);
        queue_request(KIND_PUT, CH_NEWLINE, 7'd0, 5'd0, 8'd0);
        queue_request(KIND_READ, 8'd0, 7'd127, 5'd31, 8'd0);
        queue_request(KIND_READ, 8'd0, 7'd5, 5'(ROWS - 2), 8'd0);
        queue_request(KIND_PUT_AT, CH_NEWLINE, 7'd10, 5'd3, 8'd0);
        queue_request(KIND_PUT_AT, CH_BACKSPACE, 7'd0, 5'd5, 8'h77);
        queue_request(KIND_SPARE_LO, 8'hFF, 7'd127, 5'd31, 8'hFF);
        queue_request(KIND_SPARE_HI, 8'd0, 7'd0, 5'd0, 8'd0);
        queue_request(KIND_CLEAR, 8'd0, 7'd0, 5'd0, 8'd0);
        queue_request(KIND_READ, 8'd0, 7'd0, 5'(ROWS - 2), 8'd0);
        queue_request(KIND_READ, 8'd0, 7'(COLS - 1), 5'(ROWS - 1), 8'd0);
        queue_request(KIND_MOVE, 8'd0, 7'd64, 5'd16, 8'd0);
        queue_request(KIND_PUT, CH_BACKSPACE, 7'd0, 5'd0, 8'd0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_default_attr(8'd1);
                1: set_default_attr(8'd255);
                default: set_default_attr(8'($urandom_range(255, 1)));
            endcase
            send_idle_pct = (phase == 1) ? 82 : (phase == 3) ? 28 : 0;
            recv_stall_pct = (phase == 2) ? 82 : (phase == 3) ? 28 : 0;
            queued = 0;
            while (queued < RANDOM_PER_PHASE)
                queued += queue_random_burst();
        end
        set_default_attr(DFLT_ATTR_RST);
        queue_request(KIND_PUT, "e", 7'd0, 5'd0, 8'd0);

        wait_idle();
        repeat (32) @(posedge clk);
        $display("checked %0d results: %0d reads, %0d clears, %0d scrolling requests",
                 checked_count, read_count, clear_count, scroll_count);
        $display("four sender/receiver idle patterns, default attribute at 1, 255 and others");
        if (mismatch_count == 0 && status_due.size() == 0)
            $display("[text_console_cell_writer] OK");
        else
            $display("[text_console_cell_writer] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
src/tccw_pkg.sv
src/tccw_ram.sv
src/tccw_dpath.sv
src/tccw_ctrl.sv
src/text_console_cell_writer.sv
tb/tb_text_console_cell_writer.sv
